[design/lcfp_pkg.sv]
// ----------------------------------------------------------------------------
// lcfp_pkg
// shared constants, types and helper functions of the led cube frame player
// ----------------------------------------------------------------------------
package lcfp_pkg;

  // frame table geometry
  localparam int unsigned TABLE_DEPTH   = 128;
  localparam int unsigned IDX_W         = $clog2(TABLE_DEPTH);

  // field widths
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned ENTRY_IDX_W   = 7;
  localparam int unsigned PATTERN_W     = 27;
  localparam int unsigned DUR_W         = 20;
  localparam int unsigned PASS_W        = 5;
  localparam int unsigned TICKS_W       = 8;
  localparam int unsigned PLANE_W       = 2;
  localparam int unsigned ROUNDS_W      = 11;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TICKS = 1'b1;

  localparam logic [PASS_W-1:0]  PASS_COUNT_RST  = 5'd30;
  localparam logic [TICKS_W-1:0] PLANE_TICKS_RST = 8'd30;

  // ground and plane select codes
  localparam logic [2:0] GND_IDLE      = 3'b111;
  localparam logic [2:0] GND_OFF       = 3'b000;
  localparam logic [2:0] PLANE_TOP_SEL = 3'b100;
  localparam logic [PLANE_W-1:0] PLANE_TOP    = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_MID    = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_BOTTOM = 2'd2;

  // rounds per frame: duration / ROUND_DIVISOR, by exact reciprocal multiply
  localparam int unsigned ROUND_DIVISOR = 540;
  localparam int unsigned ROUNDS_MAX    = 2047;
  localparam int unsigned ROUND_SHIFT   = DUR_W + $clog2(ROUND_DIVISOR);
  localparam longint unsigned ROUND_MUL =
    ((64'd1 << ROUND_SHIFT) + 64'(ROUND_DIVISOR) - 64'd1) / 64'(ROUND_DIVISOR);
  localparam int unsigned ROUND_MUL_W   = $clog2(ROUND_MUL + 1);
  localparam int unsigned ROUND_PROD_W  = DUR_W + ROUND_MUL_W;

  // one frame table entry, kept in pre-digested form
  typedef struct packed {
    logic                 nonzero;  // duration was not zero
    logic [ROUNDS_W-1:0]  rounds;   // saturated round count
    logic [PATTERN_W-1:0] pattern;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  function automatic logic [ROUNDS_W-1:0] rounds_of(input logic [DUR_W-1:0] dur);
    logic [ROUND_PROD_W-1:0] prod;
    logic [ROUND_PROD_W-1:0] quo;
    begin
      prod = ROUND_PROD_W'(dur) * ROUND_PROD_W'(ROUND_MUL);
      quo  = prod >> ROUND_SHIFT;
      if (quo > ROUND_PROD_W'(ROUNDS_MAX)) begin
        rounds_of = ROUNDS_W'(ROUNDS_MAX);
      end else begin
        rounds_of = quo[ROUNDS_W-1:0];
      end
    end
  endfunction

  // 9-bit plane pattern to column byte; back-left pin comes out separately
  function automatic logic [7:0] column_of(input logic [8:0] p);
    begin
      column_of = {p[7], p[6], p[5], p[2], p[4], p[1], p[3], p[0]};
    end
  endfunction

endpackage

[design/lcfp_store.sv]
// ----------------------------------------------------------------------------
// lcfp_store
// frame table memory: one write port, two registered read ports with
// write forwarding for a write that lands on a read address in the same cycle
// ----------------------------------------------------------------------------
module lcfp_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcfp_pkg::wr_req_t       wr_i,
  input  logic [lcfp_pkg::IDX_W-1:0] rd_addr_a_i,
  input  logic [lcfp_pkg::IDX_W-1:0] rd_addr_b_i,
  output lcfp_pkg::entry_t        rd_a_o,
  output lcfp_pkg::entry_t        rd_b_o
);
  import lcfp_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_a_q;
  entry_t rd_b_q;
  entry_t wr_data_q;
  logic   hit_a_q;
  logic   hit_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q    <= mem[rd_addr_a_i];
    rd_b_q    <= mem[rd_addr_b_i];
    wr_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      hit_a_q <= wr_i.en && (wr_i.addr == rd_addr_a_i);
      hit_b_q <= wr_i.en && (wr_i.addr == rd_addr_b_i);
    end
  end

  assign rd_a_o = hit_a_q ? wr_data_q : rd_a_q;
  assign rd_b_o = hit_b_q ? wr_data_q : rd_b_q;

endmodule

[design/led_cube_frame_player.sv]
// ----------------------------------------------------------------------------
// led_cube_frame_player
// animation player for a plane-multiplexed 3x3x3 led cube
// ----------------------------------------------------------------------------
// output: a result is in the output register the cycle after its transfer
// throughput: one item per cycle while results are taken; both memory ports
//   read the current and next entry every cycle, so frame changes add no wait
// reset: control state and output valid cleared, pass_count and plane_ticks
//   go to 30; the frame table is not cleared and holds nothing until written
// ----------------------------------------------------------------------------
module led_cube_frame_player (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [lcfp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lcfp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lcfp_pkg::CMD_W-1:0]           cmd_i,
  input  logic [lcfp_pkg::ENTRY_IDX_W-1:0]     entry_index_i,
  input  logic [lcfp_pkg::PATTERN_W-1:0]       cube_bits_i,
  input  logic [lcfp_pkg::DUR_W-1:0]           frame_duration_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [7:0]                           column_port_o,
  output logic                                 back_left_drive_o,
  output logic [2:0]                           plane_grounds_o,
  output logic                                 playing_o,
  output logic                                 finished_o
);
  import lcfp_pkg::*;

  // configuration registers
  logic [PASS_W-1:0]  pass_count_q;
  logic [TICKS_W-1:0] plane_ticks_q;

  // playback state
  logic [IDX_W-1:0]    frame_index_q,  frame_index_d;
  logic [PASS_W-1:0]   pass_index_q,   pass_index_d;
  logic [ROUNDS_W-1:0] rounds_left_q,  rounds_left_d;
  logic [PLANE_W-1:0]  active_plane_q, active_plane_d;
  logic [TICKS_W-1:0]  tick_count_q,   tick_count_d;
  logic                running_q,      running_d;
  logic                done_q,         done_d;

  // round count of entry 0, kept aside for start and pass wrap
  logic [ROUNDS_W-1:0] e0_rounds_q;

  // output register
  logic                out_valid_q;
  logic [7:0]          column_q;
  logic                back_left_q;
  logic [2:0]          grounds_q;
  logic                playing_q;
  logic                finished_q;

  // per-item working signals
  logic                in_xfer;
  wr_req_t             wr_req;
  entry_t              cur_entry;
  entry_t              nxt_entry;
  logic [IDX_W-1:0]    nxt_addr;
  logic                pass_ends;
  logic [PASS_W-1:0]   pass_nx;
  logic [PASS_W-1:0]   pass_limit;
  logic [TICKS_W:0]    tick_limit;
  logic [TICKS_W:0]    tick_inc;
  logic [PLANE_W-1:0]  plane_sat;
  logic [8:0]          plane_pat;
  logic                advance;
  logic [7:0]          column_d;
  logic                back_left_d;
  logic [2:0]          grounds_d;

  // a new item moves in whenever the result register is free or being taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // table write, with the round count worked out on the way in
  always_comb begin
    wr_req.en           = in_xfer && (cmd_i == CMD_WRITE)
                          && (int'(entry_index_i) < TABLE_DEPTH);
    wr_req.addr         = IDX_W'(entry_index_i);
    wr_req.data.nonzero = (frame_duration_i != '0);
    wr_req.data.rounds  = rounds_of(frame_duration_i);
    wr_req.data.pattern = cube_bits_i;
  end

  // port a follows the frame being shown, port b the one after it
  assign nxt_addr = frame_index_d + IDX_W'(1);

  lcfp_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr_req),
    .rd_addr_a_i (frame_index_d),
    .rd_addr_b_i (nxt_addr),
    .rd_a_o      (cur_entry),
    .rd_b_o      (nxt_entry)
  );

  // register value zero behaves as one
  assign pass_limit = (pass_count_q == '0) ? PASS_W'(1) : pass_count_q;
  assign tick_limit = (plane_ticks_q == '0) ? (TICKS_W+1)'(1) : {1'b0, plane_ticks_q};
  assign tick_inc   = {1'b0, tick_count_q} + (TICKS_W+1)'(1);
  assign plane_sat  = (active_plane_q > PLANE_BOTTOM) ? PLANE_BOTTOM : active_plane_q;
  assign pass_nx    = pass_index_q + PASS_W'(1);

  // pass ends at the last table slot or before a zero-duration entry
  assign pass_ends  = (frame_index_q == IDX_W'(TABLE_DEPTH - 1)) || !nxt_entry.nonzero;

  always_comb begin
    if (plane_sat == PLANE_TOP) begin
      plane_pat = cur_entry.pattern[8:0];
    end else if (plane_sat == PLANE_MID) begin
      plane_pat = cur_entry.pattern[17:9];
    end else begin
      plane_pat = cur_entry.pattern[26:18];
    end
  end

  // next state and drive for the item being taken
  always_comb begin
    frame_index_d  = frame_index_q;
    pass_index_d   = pass_index_q;
    rounds_left_d  = rounds_left_q;
    active_plane_d = active_plane_q;
    tick_count_d   = tick_count_q;
    running_d      = running_q;
    done_d         = done_q;
    column_d       = '0;
    back_left_d    = 1'b0;
    grounds_d      = GND_IDLE;
    advance        = 1'b0;

    if (in_xfer) begin
      unique case (cmd_i)
        CMD_START: begin
          running_d      = 1'b1;
          done_d         = 1'b0;
          pass_index_d   = '0;
          frame_index_d  = '0;
          rounds_left_d  = e0_rounds_q;
          active_plane_d = PLANE_TOP;
          tick_count_d   = '0;
        end
        CMD_TICK: begin
          if (running_q) begin
            if (rounds_left_q == '0) begin
              // zero-round frame: one idle tick, then move on
              advance = 1'b1;
            end else begin
              column_d    = column_of(plane_pat);
              back_left_d = plane_pat[8];
              grounds_d   = GND_IDLE & ~(PLANE_TOP_SEL >> plane_sat);
              if (tick_inc >= tick_limit) begin
                tick_count_d = '0;
                if (plane_sat == PLANE_BOTTOM) begin
                  active_plane_d = PLANE_TOP;
                  rounds_left_d  = rounds_left_q - ROUNDS_W'(1);
                  advance        = (rounds_left_d == '0);
                end else begin
                  active_plane_d = plane_sat + PLANE_W'(1);
                end
              end else begin
                tick_count_d = tick_inc[TICKS_W-1:0];
              end
            end
          end
        end
        default: begin
          // table writes and the unused code change no playback state
        end
      endcase
    end

    if (advance) begin
      if (pass_ends) begin
        pass_index_d = pass_nx;
        if (pass_nx >= pass_limit) begin
          running_d = 1'b0;
          done_d    = 1'b1;
        end else begin
          frame_index_d  = '0;
          rounds_left_d  = e0_rounds_q;
          active_plane_d = PLANE_TOP;
          tick_count_d   = '0;
        end
      end else begin
        frame_index_d  = frame_index_q + IDX_W'(1);
        rounds_left_d  = nxt_entry.rounds;
        active_plane_d = PLANE_TOP;
        tick_count_d   = '0;
      end
    end

    // after the last pass every pin goes dark, grounds included
    if (done_d) begin
      column_d    = '0;
      back_left_d = 1'b0;
      grounds_d   = GND_OFF;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_count_q  <= PASS_COUNT_RST;
      plane_ticks_q <= PLANE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PASS_COUNT:  pass_count_q  <= cfg_data_i[PASS_W-1:0];
        CFG_PLANE_TICKS: plane_ticks_q <= cfg_data_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_index_q  <= '0;
      pass_index_q   <= '0;
      rounds_left_q  <= '0;
      active_plane_q <= PLANE_TOP;
      tick_count_q   <= '0;
      running_q      <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      frame_index_q  <= frame_index_d;
      pass_index_q   <= pass_index_d;
      rounds_left_q  <= rounds_left_d;
      active_plane_q <= active_plane_d;
      tick_count_q   <= tick_count_d;
      running_q      <= running_d;
      done_q         <= done_d;
    end
  end

  // copy of entry 0 round count, follows every write to entry 0
  always_ff @(posedge clk_i) begin
    if (wr_req.en && (wr_req.addr == '0)) begin
      e0_rounds_q <= wr_req.data.rounds;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      column_q    <= column_d;
      back_left_q <= back_left_d;
      grounds_q   <= grounds_d;
      playing_q   <= running_d;
      finished_q  <= done_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign column_port_o     = column_q;
  assign back_left_drive_o = back_left_q;
  assign plane_grounds_o   = grounds_q;
  assign playing_o         = playing_q;
  assign finished_o        = finished_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // playing and finished exclude each other
  a_run_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(running_q && done_q))
    else $error("running and done both set");

  // the scan never selects a fourth plane
  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_plane_q != 2'd3)
    else $error("active plane out of range");

  // a finished result drives nothing
  a_finished_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && finished_q) |-> (column_q == '0 && !back_left_q && grounds_q == GND_OFF))
    else $error("pins driven after finish");

  // a tick that lights a plane only comes from a running player
  a_lit_when_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && grounds_d != GND_IDLE && grounds_d != GND_OFF) |-> running_q)
    else $error("plane lit while stopped");

endmodule
